### rtl/msc_pkg.sv
// Shared constants, types and CORDIC gain helper for the MET xy-shift correction.
package msc_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int VertexLimitDefault = 100;
   localparam int AtanEntries        = 24;

   localparam int MagW  = 16;
   localparam int AngW  = 16;
   localparam int CntW  = 8;
   localparam int CoefW = 24;
   localparam int OutMagW = 17;
   localparam int CsrIdxW = 2;

   localparam int RotW  = 35;   // rotation x/y
   localparam int AngZW = 34;   // CORDIC angle accumulator, 2^31 = pi
   localparam int ScW   = 34;   // scaled x/y after gain removal
   localparam int CorW  = 36;   // correction term in Q16 eighths
   localparam int DiffW = 37;   // corrected x/y
   localparam int VecW  = 40;   // vectoring x/y
   localparam int GainW = 24;   // gain factor in Q24

   localparam logic [CsrIdxW-1:0] RegXSlope  = 2'd0;
   localparam logic [CsrIdxW-1:0] RegXOffset = 2'd1;
   localparam logic [CsrIdxW-1:0] RegYSlope  = 2'd2;
   localparam logic [CsrIdxW-1:0] RegYOffset = 2'd3;

   localparam logic signed [CoefW-1:0] XSlopeReset  = -24'sd12027;
   localparam logic signed [CoefW-1:0] XOffsetReset = 24'sd35832;
   localparam logic signed [CoefW-1:0] YSlopeReset  = 24'sd12600;
   localparam logic signed [CoefW-1:0] YOffsetReset = -24'sd27604;

   localparam logic [31:0] AtanTab [AtanEntries] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic zero;
      logic x_zero;
      logic y_pos;
   } msc_flags_type;

   // CORDIC gain in Q30: square root of the product of (1 + 4^-i)
   function automatic logic [63:0] gain_a_q30(input int steps);
      logic [63:0] p;
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      p = 64'd1 << 30;
      for (int i = 0; i < steps; i++) p = p + (p >> (2 * i));
      v    = p << 30;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) if (bitv > v) bitv = bitv >> 2;
      for (int j = 0; j < 32; j++) begin
         if (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      if (res == 0) res = 64'd1;
      return res;
   endfunction

endpackage

### rtl/msc_rot_stage.sv
// One registered CORDIC rotation step, driving z toward zero.
module msc_rot_stage #(
   parameter int XW  = msc_pkg::RotW,
   parameter int ZW  = msc_pkg::AngZW,
   parameter int IDX = 0,
   parameter int AW  = msc_pkg::CntW
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_v,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [XW-1:0] in_y,
   input  logic signed [ZW-1:0] in_z,
   input  logic [AW-1:0]        in_aux,
   output logic                 v_ff,
   output logic signed [XW-1:0] x_ff,
   output logic signed [XW-1:0] y_ff,
   output logic signed [ZW-1:0] z_ff,
   output logic [AW-1:0]        aux_ff
);
   logic signed [ZW-1:0] atan;
   logic signed [XW-1:0] x_in, y_in;
   logic signed [ZW-1:0] z_in;

   assign atan = ZW'($signed({1'b0, msc_pkg::AtanTab[IDX]}));

   always_comb begin
      if (in_z >= 0) begin
         x_in = in_x - (in_y >>> IDX);
         y_in = in_y + (in_x >>> IDX);
         z_in = in_z - atan;
      end else begin
         x_in = in_x + (in_y >>> IDX);
         y_in = in_y - (in_x >>> IDX);
         z_in = in_z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (enable) v_ff <= in_v;
      if (enable) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         aux_ff <= in_aux;
      end
   end
endmodule

### rtl/msc_vec_stage.sv
// One registered CORDIC vectoring step, driving y toward zero.
module msc_vec_stage #(
   parameter int XW  = msc_pkg::VecW,
   parameter int ZW  = msc_pkg::AngZW,
   parameter int IDX = 0,
   parameter int AW  = $bits(msc_pkg::msc_flags_type)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_v,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [XW-1:0] in_y,
   input  logic signed [ZW-1:0] in_z,
   input  logic [AW-1:0]        in_aux,
   output logic                 v_ff,
   output logic signed [XW-1:0] x_ff,
   output logic signed [XW-1:0] y_ff,
   output logic signed [ZW-1:0] z_ff,
   output logic [AW-1:0]        aux_ff
);
   logic signed [ZW-1:0] atan;
   logic signed [XW-1:0] x_in, y_in;
   logic signed [ZW-1:0] z_in;

   assign atan = ZW'($signed({1'b0, msc_pkg::AtanTab[IDX]}));

   always_comb begin
      if (in_y >= 0) begin
         x_in = in_x + (in_y >>> IDX);
         y_in = in_y - (in_x >>> IDX);
         z_in = in_z + atan;
      end else begin
         x_in = in_x - (in_y >>> IDX);
         y_in = in_y + (in_x >>> IDX);
         z_in = in_z - atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (enable) v_ff <= in_v;
      if (enable) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         aux_ff <= in_aux;
      end
   end
endmodule

### rtl/met_xy_shift_correction.sv
// Top level: pipelined polar-to-xy, linear vertex correction and xy-to-polar.
//
//  channel | ports                                              | flow
//  --------+----------------------------------------------------+-----------------
//  req     | req_valid, req_stall, req_met_magnitude,           | in, stall driven
//          | req_met_angle, req_vertex_count                    |   by this block
//  rsp     | rsp_valid, rsp_stall, rsp_corrected_magnitude,     | out, stall from
//          | rsp_corrected_angle                                |   the consumer
//  csr     | csr_valid, csr_ready, csr_index, csr_data          | register writes
//
// One transaction per cycle is accepted while req_stall is low. With STEPS = CORDIC_STEPS
// capped at 24, the path holds 2*STEPS+7 registers: an input stage, one stage per
// rotation step, three stages of gain removal and correction, one stage per vectoring
// step, two stages of final scaling, then the output register.
// Reset is synchronous, clears valid bits and loads the coefficient reset values.
// When rsp is stalled the next finished transaction goes into a skid register;
// only once that is full does the whole pipeline hold and req_stall rise.
module met_xy_shift_correction #(
   parameter int CORDIC_STEPS = msc_pkg::CordicStepsDefault,
   parameter int VERTEX_LIMIT = msc_pkg::VertexLimitDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [msc_pkg::MagW-1:0]             req_met_magnitude,
   input  logic signed [msc_pkg::AngW-1:0]      req_met_angle,
   input  logic [msc_pkg::CntW-1:0]             req_vertex_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [msc_pkg::OutMagW-1:0]          rsp_corrected_magnitude,
   output logic signed [msc_pkg::AngW-1:0]      rsp_corrected_angle,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [msc_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [msc_pkg::CoefW-1:0]            csr_data
);
   localparam int RW  = msc_pkg::RotW;
   localparam int ZW  = msc_pkg::AngZW;
   localparam int SW  = msc_pkg::ScW;
   localparam int CW  = msc_pkg::CorW;
   localparam int DW  = msc_pkg::DiffW;
   localparam int VW  = msc_pkg::VecW;
   localparam int KW  = msc_pkg::GainW;
   localparam int NW  = msc_pkg::CntW;
   localparam int FW  = $bits(msc_pkg::msc_flags_type);
   localparam int STEPS = (CORDIC_STEPS > msc_pkg::AtanEntries) ?
                          msc_pkg::AtanEntries : CORDIC_STEPS;
   localparam logic [63:0] GainA   = msc_pkg::gain_a_q30(STEPS);
   localparam logic [63:0] GainK64 = (64'd1 << 54) / GainA;
   localparam logic [KW-1:0] GainK = GainK64[KW-1:0];
   localparam logic signed [ZW-1:0] QuarterZ = ZW'(64'sd1073741824);
   localparam logic signed [ZW-1:0] HalfZ    = ZW'(64'sd2147483648);

   // ---------------- coefficient registers ----------------
   logic signed [msc_pkg::CoefW-1:0] x_slope_ff, x_offset_ff, y_slope_ff, y_offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_slope_ff  <= msc_pkg::XSlopeReset;
         x_offset_ff <= msc_pkg::XOffsetReset;
         y_slope_ff  <= msc_pkg::YSlopeReset;
         y_offset_ff <= msc_pkg::YOffsetReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            msc_pkg::RegXSlope:  x_slope_ff  <= csr_data;
            msc_pkg::RegXOffset: x_offset_ff <= csr_data;
            msc_pkg::RegYSlope:  y_slope_ff  <= csr_data;
            msc_pkg::RegYOffset: y_offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- global advance ----------------
   // Every stage moves while the skid register is empty.
   logic skid_v_ff;
   logic en;
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // ---------------- input stage, vertex clamp ----------------
   logic                   p0_v_ff;
   logic [msc_pkg::MagW-1:0] p0_mag_ff;
   logic signed [msc_pkg::AngW-1:0] p0_ang_ff;
   logic [NW-1:0]          p0_n_ff;
   logic [NW-1:0]          n_in;

   assign n_in = (req_vertex_count > NW'(VERTEX_LIMIT)) ? NW'(VERTEX_LIMIT)
                                                        : req_vertex_count;

   always_ff @(posedge clock) begin
      if (reset) p0_v_ff <= 1'b0;
      else if (en) p0_v_ff <= req_valid;
      if (en) begin
         p0_mag_ff <= req_met_magnitude;
         p0_ang_ff <= req_met_angle;
         p0_n_ff   <= n_in;
      end
   end

   // Fold the angle into +-pi/2 by flipping x.
   logic signed [RW-1:0] rx [STEPS+1];
   logic signed [RW-1:0] ry [STEPS+1];
   logic signed [ZW-1:0] rz [STEPS+1];
   logic [NW-1:0]        rn [STEPS+1];
   logic                 rv [STEPS+1];
   logic signed [ZW-1:0] z_raw;
   logic signed [RW-1:0] x_raw;

   always_comb begin
      z_raw = ZW'($signed({p0_ang_ff, 16'b0}));
      x_raw = RW'({p0_mag_ff, 16'b0});
      rz[0] = z_raw;
      rx[0] = x_raw;
      if (z_raw > QuarterZ) begin
         rz[0] = z_raw - HalfZ;
         rx[0] = -x_raw;
      end else if (z_raw < -QuarterZ) begin
         rz[0] = z_raw + HalfZ;
         rx[0] = -x_raw;
      end
   end
   assign ry[0] = '0;
   assign rn[0] = p0_n_ff;
   assign rv[0] = p0_v_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      msc_rot_stage #(.XW(RW), .ZW(ZW), .IDX(i), .AW(NW)) u_rot (
         .clock(clock), .reset(reset), .enable(en),
         .in_v(rv[i]), .in_x(rx[i]), .in_y(ry[i]), .in_z(rz[i]), .in_aux(rn[i]),
         .v_ff(rv[i+1]), .x_ff(rx[i+1]), .y_ff(ry[i+1]), .z_ff(rz[i+1]),
         .aux_ff(rn[i+1])
      );
   end

   // ---------------- gain removal and correction ----------------
   // Split x and y so that each product stays within one narrow multiplier.
   logic                  m1_v_ff;
   logic [40:0]           m1_xlo_ff, m1_ylo_ff;
   logic signed [42:0]    m1_xhi_ff, m1_yhi_ff;
   logic signed [31:0]    m1_cx_ff, m1_cy_ff;
   logic signed [RW-18:0] xhi, yhi;
   logic signed [KW:0]    k_s;
   logic signed [NW:0]    n_s;

   assign xhi = rx[STEPS][RW-1:17];
   assign yhi = ry[STEPS][RW-1:17];
   assign k_s = $signed({1'b0, GainK});
   assign n_s = $signed({1'b0, rn[STEPS]});

   always_ff @(posedge clock) begin
      if (reset) m1_v_ff <= 1'b0;
      else if (en) m1_v_ff <= rv[STEPS];
      if (en) begin
         m1_xlo_ff <= 41'(rx[STEPS][16:0]) * 41'(GainK);
         m1_ylo_ff <= 41'(ry[STEPS][16:0]) * 41'(GainK);
         m1_xhi_ff <= 43'(xhi) * 43'(k_s);
         m1_yhi_ff <= 43'(yhi) * 43'(k_s);
         m1_cx_ff  <= 32'(x_slope_ff) * 32'(n_s);
         m1_cy_ff  <= 32'(y_slope_ff) * 32'(n_s);
      end
   end

   logic                 m2_v_ff;
   logic signed [SW-1:0] m2_x_ff, m2_y_ff;
   logic signed [CW-1:0] m2_cx_ff, m2_cy_ff;
   logic signed [59:0]   sx, sy;
   logic signed [32:0]   tx, ty;

   always_comb begin
      sx = (60'(m1_xhi_ff) <<< 17) + $signed(60'(m1_xlo_ff)) + 60'sd8388608;
      sy = (60'(m1_yhi_ff) <<< 17) + $signed(60'(m1_ylo_ff)) + 60'sd8388608;
      tx = 33'(m1_cx_ff) + 33'(x_offset_ff);
      ty = 33'(m1_cy_ff) + 33'(y_offset_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) m2_v_ff <= 1'b0;
      else if (en) m2_v_ff <= m1_v_ff;
      if (en) begin
         m2_x_ff  <= sx[SW+23:24];
         m2_y_ff  <= sy[SW+23:24];
         m2_cx_ff <= {tx, 3'b000};
         m2_cy_ff <= {ty, 3'b000};
      end
   end

   logic                 m3_v_ff;
   logic signed [DW-1:0] m3_x_ff, m3_y_ff;

   always_ff @(posedge clock) begin
      if (reset) m3_v_ff <= 1'b0;
      else if (en) m3_v_ff <= m2_v_ff;
      if (en) begin
         m3_x_ff <= DW'(m2_x_ff) - DW'(m2_cx_ff);
         m3_y_ff <= DW'(m2_y_ff) - DW'(m2_cy_ff);
      end
   end

   // ---------------- vectoring ----------------
   logic signed [VW-1:0] vx [STEPS+1];
   logic signed [VW-1:0] vy [STEPS+1];
   logic signed [ZW-1:0] vz [STEPS+1];
   logic [FW-1:0]        vf [STEPS+1];
   logic                 vv [STEPS+1];
   msc_pkg::msc_flags_type flags_in;

   always_comb begin
      flags_in.x_zero = (m3_x_ff == 0);
      flags_in.y_pos  = (m3_y_ff > 0);
      flags_in.zero   = (m3_x_ff == 0) && (m3_y_ff == 0);
      // Left half plane: mirror through the origin and start from +-pi.
      if (m3_x_ff < 0) begin
         vx[0] = -VW'(m3_x_ff);
         vy[0] = -VW'(m3_y_ff);
         vz[0] = (m3_y_ff >= 0) ? HalfZ : -HalfZ;
      end else begin
         vx[0] = VW'(m3_x_ff);
         vy[0] = VW'(m3_y_ff);
         vz[0] = '0;
      end
   end
   assign vf[0] = flags_in;
   assign vv[0] = m3_v_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_vec
      msc_vec_stage #(.XW(VW), .ZW(ZW), .IDX(i), .AW(FW)) u_vec (
         .clock(clock), .reset(reset), .enable(en),
         .in_v(vv[i]), .in_x(vx[i]), .in_y(vy[i]), .in_z(vz[i]), .in_aux(vf[i]),
         .v_ff(vv[i+1]), .x_ff(vx[i+1]), .y_ff(vy[i+1]), .z_ff(vz[i+1]),
         .aux_ff(vf[i+1])
      );
   end

   // ---------------- final scaling and angle ----------------
   logic                 f1_v_ff;
   logic [43:0]          f1_lo_ff;
   logic [42:0]          f1_hi_ff;
   logic signed [ZW-1:0] f1_z_ff;
   msc_pkg::msc_flags_type f1_f_ff;
   logic [VW-2:0]        xc;

   assign xc = (vx[STEPS] < 0) ? '0 : vx[STEPS][VW-2:0];

   always_ff @(posedge clock) begin
      if (reset) f1_v_ff <= 1'b0;
      else if (en) f1_v_ff <= vv[STEPS];
      if (en) begin
         f1_lo_ff <= 44'(xc[19:0]) * 44'(GainK);
         f1_hi_ff <= 43'(xc[VW-2:20]) * 43'(GainK);
         f1_z_ff  <= vz[STEPS];
         f1_f_ff  <= vf[STEPS];
      end
   end

   logic                                 f2_v_ff;
   logic [msc_pkg::OutMagW-1:0]          f2_mag_ff, f2_mag_in;
   logic signed [msc_pkg::AngW-1:0]      f2_ang_ff, f2_ang_in;
   logic [64:0]                          msum;
   logic signed [ZW-1:0]                 zr;

   always_comb begin
      msum = (65'(f1_hi_ff) << 20) + 65'(f1_lo_ff) + (65'd1 << 39);
      zr   = f1_z_ff + ZW'(32768);
      // Saturate the magnitude.
      if (msum[64:40] > 25'd131071) f2_mag_in = '1;
      else f2_mag_in = msum[56:40];
      if (f1_f_ff.x_zero) f2_ang_in = f1_f_ff.y_pos ? 16'sd16384 : -16'sd16384;
      else f2_ang_in = zr[31:16];
      if (f1_f_ff.zero) begin
         f2_mag_in = '0;
         f2_ang_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) f2_v_ff <= 1'b0;
      else if (en) f2_v_ff <= f1_v_ff;
      if (en) begin
         f2_mag_ff <= f2_mag_in;
         f2_ang_ff <= f2_ang_in;
      end
   end

   // ---------------- output register and skid ----------------
   logic                             out_v_ff;
   logic [msc_pkg::OutMagW-1:0]      out_mag_ff, skid_mag_ff;
   logic signed [msc_pkg::AngW-1:0]  out_ang_ff, skid_ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || !rsp_stall) begin
         // Output free: drain skid first, else advance from the pipeline.
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= f2_v_ff;
         end
      end else if (en && f2_v_ff) begin
         // Output held: park the arriving transaction.
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || !rsp_stall) begin
         if (skid_v_ff) begin
            out_mag_ff <= skid_mag_ff;
            out_ang_ff <= skid_ang_ff;
         end else begin
            out_mag_ff <= f2_mag_ff;
            out_ang_ff <= f2_ang_ff;
         end
      end else if (en) begin
         skid_mag_ff <= f2_mag_ff;
         skid_ang_ff <= f2_ang_ff;
      end
   end

   assign rsp_valid               = out_v_ff;
   assign rsp_corrected_magnitude = out_mag_ff;
   assign rsp_corrected_angle     = out_ang_ff;
endmodule
